// File: design/afx_pkg.sv
// shared constants, types and helper functions for the framed xor-check receiver
`default_nettype none

package afx_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 25;
    localparam int VALUE_OFFSET    = 4;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

    typedef logic [7:0] byte_t;
    typedef logic [LEN_W-1:0] len_t;

    // character codes
    localparam byte_t CH_OPEN  = 8'h3C;
    localparam byte_t CH_CLOSE = 8'h3E;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_HEX_A = 8'h41;

    // decimal magnitude limits
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic  clear;
        logic  feed;
        byte_t ch;
    } parse_ctrl_t;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } parse_snap_t;

    typedef struct packed {
        logic        frame_good;
        logic        frame_bad;
        logic [31:0] value;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } result_t;

    // upper-case hex digit for one nibble
    function automatic byte_t hex_char(input logic [3:0] nib);
        byte_t c;
        if (nib < 4'd10)
        begin
            c = CH_ZERO + {4'b0000, nib};
        end
        else
        begin
            c = CH_HEX_A + {4'b0000, nib - 4'd10};
        end
        return c;
    endfunction

    // space, tab, lf, vt, ff, cr
    function automatic logic is_blank(input byte_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input byte_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // signed 32-bit value from sign and saturated magnitude
    function automatic logic [31:0] snap_value(input parse_snap_t s);
        logic [31:0] v;
        if (s.neg)
        begin
            v = 32'd0 - s.mag;
        end
        else if (s.mag > VALUE_MAX)
        begin
            v = VALUE_MAX;
        end
        else
        begin
            v = s.mag;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/afx_in_if.sv
// input byte channel
`default_nettype none

interface afx_in_if;
    logic          valid;
    logic          ready;
    afx_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/afx_out_if.sv
// result channel
`default_nettype none

interface afx_out_if;
    logic               valid;
    logic               ready;
    logic               frame_good;
    logic               frame_bad;
    logic signed [31:0] value;
    logic        [31:0] good_count;
    logic        [31:0] bad_count;

    modport source (output valid, output frame_good, output frame_bad, output value,
                    output good_count, output bad_count, input ready);
    modport sink   (input valid, input frame_good, input frame_bad, input value,
                    input good_count, input bad_count, output ready);
endinterface

`default_nettype wire

// File: design/ascii_frame_xor_check_receiver.sv
// top level of the framed xor-check receiver
//
// Usage: one received byte per item on rx; one result item per accepted byte
// on result. '<' opens a frame, '>' closes it and checks the hex xor checksum
// that follows the last ':'. frame_good asks the host to send an ACK;
// frame_bad marks a bad close or an overrun of the 25-byte buffer.
// value, good_count and bad_count are the values after the byte.
// The result for a byte is registered in the output buffer before it is presented.
// Throughput: one byte per cycle unless stalled; checksum, colon snapshot and
// decimal parse are carried along byte by byte, so a close needs no extra pass.
// Stalls: a two-entry output buffer lets one more byte in while a result is
// held; rx.ready drops only when both entries are full, and recovers the cycle
// after result.ready returns.
// Reset: asynchronous, active low; empties the frame, clears both counts and
// the value, and empties the output buffer. No clearing pass is needed.
`default_nettype none

module ascii_frame_xor_check_receiver (
    input  wire        clk,
    input  wire        rst_n,
    afx_in_if.sink     rx,
    afx_out_if.source  result
);

    logic                 acc;
    logic                 buf_ready;
    afx_pkg::byte_t       ch;

    afx_pkg::len_t        len_reg, len_next;
    afx_pkg::byte_t       xor_all_reg, xor_all_next;
    logic                 found_reg, found_next;
    logic [1:0]           tail_len_reg, tail_len_next;
    logic [31:0]          good_cnt_reg, good_cnt_next;
    logic [31:0]          bad_cnt_reg, bad_cnt_next;
    logic [31:0]          value_reg, value_next;

    afx_pkg::byte_t       sep_xor_reg, sep_xor_next;
    afx_pkg::byte_t       tail0_reg, tail0_next;
    afx_pkg::byte_t       tail1_reg, tail1_next;
    afx_pkg::parse_snap_t snap_reg, snap_next;

    afx_pkg::parse_snap_t parse_now;
    afx_pkg::parse_ctrl_t pctrl;
    afx_pkg::result_t     res;

    logic                 is_open;
    logic                 is_close;
    logic                 has_room;
    logic                 append;
    logic                 good_now;
    logic                 bad_now;
    logic                 sum_short;
    afx_pkg::byte_t       exp0;
    afx_pkg::byte_t       exp1;
    logic                 sum_match;

    assign acc      = rx.valid && buf_ready;
    assign rx.ready = buf_ready;
    assign ch       = rx.rx_byte;

    // byte classes
    assign is_open  = (ch == afx_pkg::CH_OPEN);
    assign is_close = (ch == afx_pkg::CH_CLOSE);
    assign has_room = (len_reg < afx_pkg::len_t'(afx_pkg::MAX_FRAME_BYTES));
    assign append   = !is_open && !is_close && has_room;

    // expected checksum text and comparison with the text after the colon
    assign sum_short = (sep_xor_reg < 8'd16);
    assign exp0      = sum_short ? afx_pkg::hex_char(sep_xor_reg[3:0])
                                 : afx_pkg::hex_char(sep_xor_reg[7:4]);
    assign exp1      = afx_pkg::hex_char(sep_xor_reg[3:0]);
    assign sum_match = sum_short
                     ? ((tail_len_reg == 2'd1) && (tail0_reg == exp0))
                     : ((tail_len_reg == 2'd2) && (tail0_reg == exp0) && (tail1_reg == exp1));

    assign good_now = is_close && found_reg && sum_match;
    assign bad_now  = (is_close && !(found_reg && sum_match))
                    || (!is_open && !is_close && !has_room);

    // decimal parser control
    assign pctrl.clear = acc && !append;
    assign pctrl.feed  = acc && append && (int'(len_reg) >= afx_pkg::VALUE_OFFSET);
    assign pctrl.ch    = ch;

    afx_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pctrl),
        .snap  (parse_now)
    );

    // frame tracking next state
    always_comb
    begin
        len_next      = len_reg;
        xor_all_next  = xor_all_reg;
        found_next    = found_reg;
        tail_len_next = tail_len_reg;
        good_cnt_next = good_cnt_reg;
        bad_cnt_next  = bad_cnt_reg;
        value_next    = value_reg;
        sep_xor_next  = sep_xor_reg;
        tail0_next    = tail0_reg;
        tail1_next    = tail1_reg;
        snap_next     = snap_reg;
        if (acc)
        begin
            if (append)
            begin
                len_next     = len_reg + afx_pkg::len_t'(1);
                xor_all_next = xor_all_reg ^ ch;
                if (ch == afx_pkg::CH_COLON)
                begin
                    found_next    = 1'b1;
                    sep_xor_next  = xor_all_reg;
                    tail_len_next = 2'd0;
                    snap_next     = parse_now;
                end
                else if (found_reg)
                begin
                    if (tail_len_reg == 2'd0)
                    begin
                        tail0_next = ch;
                    end
                    if (tail_len_reg == 2'd1)
                    begin
                        tail1_next = ch;
                    end
                    if (tail_len_reg != 2'd3)
                    begin
                        tail_len_next = tail_len_reg + 2'd1;
                    end
                end
            end
            else
            begin
                // open, close or overrun: empty the frame
                len_next      = '0;
                xor_all_next  = 8'd0;
                found_next    = 1'b0;
                tail_len_next = 2'd0;
            end
            if (good_now)
            begin
                good_cnt_next = good_cnt_reg + 32'd1;
                value_next    = afx_pkg::snap_value(snap_reg);
            end
            if (bad_now)
            begin
                bad_cnt_next = bad_cnt_reg + 32'd1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            xor_all_reg  <= 8'd0;
            found_reg    <= 1'b0;
            tail_len_reg <= 2'd0;
            good_cnt_reg <= 32'd0;
            bad_cnt_reg  <= 32'd0;
            value_reg    <= 32'd0;
        end
        else
        begin
            len_reg      <= len_next;
            xor_all_reg  <= xor_all_next;
            found_reg    <= found_next;
            tail_len_reg <= tail_len_next;
            good_cnt_reg <= good_cnt_next;
            bad_cnt_reg  <= bad_cnt_next;
            value_reg    <= value_next;
        end
    end

    // colon snapshot and checksum text, only read once a colon is seen
    always_ff @(posedge clk)
    begin
        sep_xor_reg <= sep_xor_next;
        tail0_reg   <= tail0_next;
        tail1_reg   <= tail1_next;
        snap_reg    <= snap_next;
    end

    // result item for this byte
    assign res.frame_good = good_now;
    assign res.frame_bad  = bad_now;
    assign res.value      = value_next;
    assign res.good_count = good_cnt_next;
    assign res.bad_count  = bad_cnt_next;

    afx_outreg u_outreg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (acc),
        .data   (res),
        .ready  (buf_ready),
        .result (result)
    );

    // the frame length stays within the buffer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= afx_pkg::len_t'(afx_pkg::MAX_FRAME_BYTES))
        else $error("frame length beyond buffer");

    // a close always leaves an empty frame with no colon
    a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
        acc && is_close |=> (len_reg == '0) && !found_reg && (xor_all_reg == 8'd0))
        else $error("frame not emptied on close");

    // on a good close the good count moves up by one and the bad count stays
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        acc && good_now |=> (good_cnt_reg == $past(good_cnt_reg) + 32'd1)
                            && (bad_cnt_reg == $past(bad_cnt_reg)))
        else $error("good frame not counted");

endmodule

`default_nettype wire

// File: design/afx_parse.sv
// running atol-style decimal parser over the payload bytes of a frame
`default_nettype none

module afx_parse (
    input  wire                  clk,
    input  wire                  rst_n,
    input  afx_pkg::parse_ctrl_t ctrl,
    output afx_pkg::parse_snap_t snap
);

    afx_pkg::parse_phase_t phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [31:0]           mag_reg, mag_next;
    logic [35:0]           mag_ext;
    logic [35:0]           acc;
    logic [31:0]           acc_sat;

    // magnitude times ten plus the new digit, clipped at 2^31
    assign mag_ext = {4'b0000, mag_reg};
    assign acc     = (mag_ext << 3) + (mag_ext << 1) + {32'd0, ctrl.ch[3:0]};
    assign acc_sat = (acc > {4'b0000, afx_pkg::MAG_LIMIT}) ? afx_pkg::MAG_LIMIT : acc[31:0];

    assign snap.neg = neg_reg;
    assign snap.mag = mag_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= afx_pkg::PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (ctrl.clear)
        begin
            phase_next = afx_pkg::PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = 32'd0;
        end
        else if (ctrl.feed)
        begin
            case (phase_reg)
                afx_pkg::PH_SKIP:
                begin
                    if (afx_pkg::is_blank(ctrl.ch))
                    begin
                        phase_next = afx_pkg::PH_SKIP;
                    end
                    else if (ctrl.ch == afx_pkg::CH_PLUS)
                    begin
                        phase_next = afx_pkg::PH_DIGITS;
                    end
                    else if (ctrl.ch == afx_pkg::CH_MINUS)
                    begin
                        phase_next = afx_pkg::PH_DIGITS;
                        neg_next   = 1'b1;
                    end
                    else if (afx_pkg::is_digit(ctrl.ch))
                    begin
                        phase_next = afx_pkg::PH_DIGITS;
                        mag_next   = acc_sat;
                    end
                    else
                    begin
                        phase_next = afx_pkg::PH_DONE;
                    end
                end
                afx_pkg::PH_DIGITS:
                begin
                    if (afx_pkg::is_digit(ctrl.ch))
                    begin
                        mag_next = acc_sat;
                    end
                    else
                    begin
                        phase_next = afx_pkg::PH_DONE;
                    end
                end
                afx_pkg::PH_DONE:
                begin
                    phase_next = afx_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = afx_pkg::PH_DONE;
                end
            endcase
        end
    end

    // magnitude never passes the clip point
    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= afx_pkg::MAG_LIMIT)
        else $error("parser magnitude above limit");

    // a clear always returns to the blank-skipping phase with nothing held
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (phase_reg == afx_pkg::PH_SKIP) && (mag_reg == 32'd0) && !neg_reg)
        else $error("parser not cleared");

    // once finished, the parse holds its result until cleared
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == afx_pkg::PH_DONE) && !ctrl.clear |=> $stable(mag_reg) && $stable(neg_reg))
        else $error("finished parse changed");

endmodule

`default_nettype wire

// File: design/afx_outreg.sv
// two-entry result buffer: output register plus skid register
`default_nettype none

module afx_outreg (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  afx_pkg::result_t  data,
    output logic              ready,
    afx_out_if.source         result
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    afx_pkg::result_t out_data_reg;
    afx_pkg::result_t skid_data_reg;
    logic             head_take;

    assign head_take = out_valid_reg && result.ready;
    assign ready     = !skid_valid_reg;

    assign result.valid      = out_valid_reg;
    assign result.frame_good = out_data_reg.frame_good;
    assign result.frame_bad  = out_data_reg.frame_bad;
    assign result.value      = out_data_reg.value;
    assign result.good_count = out_data_reg.good_count;
    assign result.bad_count  = out_data_reg.bad_count;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (head_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load)
        begin
            if (out_valid_reg && !head_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (head_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (head_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (load)
        begin
            if (out_valid_reg && !head_take)
            begin
                skid_data_reg <= data;
            end
            else
            begin
                out_data_reg <= data;
            end
        end
    end

    // the skid entry is only used behind a held output
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item without output item");

    // a waiting skid item moves up when the output item is taken
    a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && result.ready |=> out_valid_reg && (out_data_reg == $past(skid_data_reg)))
        else $error("skid item lost");

    // a loaded item with an empty buffer shows up at the output
    a_load_show: assert property (@(posedge clk) disable iff (!rst_n)
        load && !out_valid_reg |=> out_valid_reg && (out_data_reg == $past(data)))
        else $error("loaded item not presented");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the framed xor-check receiver: directed frames, then random traffic
`timescale 1ns / 100ps

module tb_top;

    import afx_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 170;
    localparam int MAX_REPORTS    = 100;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TEXT,
        ROW_FRAME
    } row_kind_t;

    // one line of the directed stimulus
    typedef struct {
        row_kind_t kind;
        byte_t     ch;
        int        reps;
        string     text;
        logic      pinned;
        result_t   fixed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    afx_in_if  rx_if();
    afx_out_if res_if();

    ascii_frame_xor_check_receiver u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    // frame decoder state mirrored by the bench
    byte_t       frame_bytes [MAX_FRAME_BYTES];
    int          frame_len  = 0;
    logic [31:0] good_total = '0;
    logic [31:0] bad_total  = '0;
    logic [31:0] held_value = '0;

    result_t   pending_status [$];
    byte_t     tx_bytes [$];
    stim_row_t stim_rows [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int bytes_sent    = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;
    int phase_end;
    result_t want;
    byte_t   row_sum;

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // upper-case hex text of a checksum, no leading zero
    function automatic string hex_text(input byte_t s);
        string t;
        t = $sformatf("%0h", s);
        return t.toupper();
    endfunction

    // status expected after one received byte; advances the mirrored state
    function automatic result_t decode_byte(input byte_t c);
        result_t     r;
        int          colon_at;
        int          tail_len;
        int          i;
        byte_t       sum;
        string       sum_str;
        logic        ok;
        logic        neg;
        longint unsigned mag;
        r = '0;
        if (c == CH_OPEN)
        begin
            frame_len = 0;
        end
        else if (c == CH_CLOSE)
        begin
            // split at the last colon
            colon_at = -1;
            for (i = 0; i < frame_len; i++)
            begin
                if (frame_bytes[i] == CH_COLON)
                begin
                    colon_at = i;
                end
            end
            ok = (colon_at >= 0);
            if (ok)
            begin
                // checksum text must match exactly, no leading zero, upper case
                sum = '0;
                for (i = 0; i < colon_at; i++)
                begin
                    sum ^= frame_bytes[i];
                end
                sum_str  = hex_text(sum);
                tail_len = frame_len - colon_at - 1;
                ok = (tail_len == sum_str.len());
                for (i = 0; ok && i < tail_len; i++)
                begin
                    ok = (frame_bytes[colon_at + 1 + i] == byte_t'(sum_str[i]));
                end
            end
            if (ok)
            begin
                // signed decimal from the payload, saturating to 32 bits
                held_value = '0;
                if (colon_at > VALUE_OFFSET)
                begin
                    i   = VALUE_OFFSET;
                    neg = 1'b0;
                    mag = 0;
                    while (i < colon_at && (frame_bytes[i] == CH_SPACE ||
                           (frame_bytes[i] >= CH_TAB && frame_bytes[i] <= CH_CR)))
                    begin
                        i++;
                    end
                    if (i < colon_at && (frame_bytes[i] == CH_PLUS || frame_bytes[i] == CH_MINUS))
                    begin
                        neg = (frame_bytes[i] == CH_MINUS);
                        i++;
                    end
                    while (i < colon_at && frame_bytes[i] >= CH_ZERO && frame_bytes[i] <= CH_NINE)
                    begin
                        mag = mag * 10 + (frame_bytes[i] - CH_ZERO);
                        if (mag > 64'h8000_0000)
                        begin
                            mag = 64'h8000_0000;
                        end
                        i++;
                    end
                    if (neg)
                    begin
                        held_value = 32'd0 - mag[31:0];
                    end
                    else if (mag > 64'h7FFF_FFFF)
                    begin
                        held_value = 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        held_value = mag[31:0];
                    end
                end
                good_total++;
                r.frame_good = 1'b1;
            end
            else
            begin
                bad_total++;
                r.frame_bad = 1'b1;
            end
            frame_len = 0;
        end
        else if (frame_len < MAX_FRAME_BYTES)
        begin
            frame_bytes[frame_len] = c;
            frame_len++;
        end
        else
        begin
            // overrun: byte dropped, buffer emptied
            bad_total++;
            r.frame_bad = 1'b1;
            frame_len = 0;
        end
        r.value      = held_value;
        r.good_count = good_total;
        r.bad_count  = bad_total;
        return r;
    endfunction

    function automatic result_t make_status(input logic g, input logic b, input logic [31:0] v,
                                            input logic [31:0] gc, input logic [31:0] bc);
        result_t r;
        r.frame_good = g;
        r.frame_bad  = b;
        r.value      = v;
        r.good_count = gc;
        r.bad_count  = bc;
        return r;
    endfunction

    // any byte that is not a frame delimiter
    function automatic byte_t data_byte();
        byte_t c;
        c = byte_t'($urandom_range(255));
        while (c == CH_OPEN || c == CH_CLOSE)
        begin
            c = byte_t'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic byte_t xor_from(input int first);
        byte_t s;
        s = '0;
        for (int i = first; i < tx_bytes.size(); i++)
        begin
            s ^= tx_bytes[i];
        end
        return s;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            tx_bytes.push_back(byte_t'(s[i]));
        end
    endtask

    task automatic add_row(input row_kind_t kind, input byte_t ch, input int reps,
                           input string text, input logic pinned, input result_t fixed);
        stim_row_t r;
        r.kind   = kind;
        r.ch     = ch;
        r.reps   = reps;
        r.text   = text;
        r.pinned = pinned;
        r.fixed  = fixed;
        stim_rows.push_back(r);
    endtask

    // one byte through the input handshake, expectation queued on acceptance
    task automatic send_byte(input byte_t c, input logic pinned, input result_t fixed);
        result_t predicted;
        while ($urandom_range(99) < in_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= c;
        do
            @(posedge clk);
        while (!rx_if.ready);
        predicted = decode_byte(c);
        pending_status.push_back(pinned ? fixed : predicted);
        bytes_sent++;
    endtask

    task automatic flush_bytes(input logic pin_last, input result_t fixed);
        for (int i = 0; i < tx_bytes.size(); i++)
        begin
            send_byte(tx_bytes[i], pin_last && (i == tx_bytes.size() - 1), fixed);
        end
        tx_bytes.delete();
    endtask

    // mostly well-formed frames with random content, some corrupted
    task automatic build_random_frame();
        int    mode;
        int    first;
        int    n_pre;
        int    n_dig;
        byte_t sum;
        string chk;
        mode = $urandom_range(99);
        if ($urandom_range(9) != 0)
        begin
            tx_bytes.push_back(CH_OPEN);
        end
        first = tx_bytes.size();
        if (mode >= 93)
        begin
            n_pre = MAX_FRAME_BYTES - 3 + $urandom_range(8);
        end
        else if ($urandom_range(9) == 0)
        begin
            n_pre = $urandom_range(VALUE_OFFSET);
        end
        else
        begin
            n_pre = VALUE_OFFSET;
        end
        repeat (n_pre)
        begin
            tx_bytes.push_back(($urandom_range(15) == 0) ? CH_COLON : data_byte());
        end
        // payload: blanks, sign, digits, maybe a stray byte
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                tx_bytes.push_back(($urandom_range(5) == 0) ? CH_SPACE
                                   : byte_t'(CH_TAB + $urandom_range(4)));
            end
        end
        case ($urandom_range(3))
            0: tx_bytes.push_back(CH_PLUS);
            1: tx_bytes.push_back(CH_MINUS);
            default: ;
        endcase
        n_dig = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(6);
        repeat (n_dig)
        begin
            tx_bytes.push_back(byte_t'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(7) == 0)
        begin
            tx_bytes.push_back(data_byte());
        end
        // checksum tail unless the colon is left out
        if (mode < 88 || mode >= 93)
        begin
            sum = xor_from(first);
            if (mode >= 70 && mode < 78)
            begin
                sum ^= byte_t'(1 << $urandom_range(7));
            end
            chk = hex_text(sum);
            if (mode >= 78 && mode < 83)
            begin
                chk = {"0", chk};
            end
            else if (mode >= 83 && mode < 88)
            begin
                chk = chk.tolower();
            end
            tx_bytes.push_back(CH_COLON);
            push_text(chk);
        end
        if ($urandom_range(19) != 0)
        begin
            tx_bytes.push_back(CH_CLOSE);
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        end
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_status.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result, expected none actual good=%b bad=%b",
                             $time, res_if.frame_good, res_if.frame_bad);
                end
            end
            else
            begin
                want = pending_status.pop_front();
                report_field("frame_good", want.frame_good, res_if.frame_good);
                report_field("frame_bad", want.frame_bad, res_if.frame_bad);
                report_field("value", want.value, res_if.value);
                report_field("good_count", want.good_count, res_if.good_count);
                report_field("bad_count", want.bad_count, res_if.bad_count);
            end
        end
    end

    // cycles without any item moving
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        res_if.ready   = 1'b0;

        // directed table: empty close, extreme bytes, no colon, short payload,
        // sign and blanks, saturation, bad checksums, last colon, restart, overrun
        add_row(ROW_BYTE, CH_CLOSE, 1, "", 1'b1, make_status(0, 1, 0, 0, 1));
        add_row(ROW_BYTE, 8'h00, 1, "", 1'b1, make_status(0, 0, 0, 0, 1));
        add_row(ROW_BYTE, 8'hFF, 1, "", 1'b1, make_status(0, 0, 0, 0, 1));
        add_row(ROW_BYTE, CH_CLOSE, 1, "", 1'b1, make_status(0, 1, 0, 0, 2));
        add_row(ROW_FRAME, 8'h00, 0, "", 1'b1, make_status(1, 0, 0, 1, 2));
        add_row(ROW_FRAME, 8'h00, 0, "ABCD-7", 1'b1, make_status(1, 0, 32'hFFFF_FFF9, 2, 2));
        add_row(ROW_FRAME, 8'h00, 0, "id=0\t +123x", 1'b0, '0);
        add_row(ROW_FRAME, 8'h00, 0, "abcd99999999999", 1'b1,
                make_status(1, 0, 32'h7FFF_FFFF, 4, 2));
        add_row(ROW_FRAME, 8'h00, 0, "abcd-99999999999", 1'b1,
                make_status(1, 0, 32'h8000_0000, 5, 2));
        add_row(ROW_FRAME, 8'h00, 0, "abcd", 1'b1, make_status(1, 0, 0, 6, 2));
        add_row(ROW_TEXT, 8'h00, 0, "<abc:00>", 1'b1, make_status(0, 1, 0, 6, 3));
        add_row(ROW_TEXT, 8'h00, 0, "<\n:0A>", 1'b1, make_status(0, 1, 0, 6, 4));
        add_row(ROW_TEXT, 8'h00, 0, "<\n:a>", 1'b1, make_status(0, 1, 0, 6, 5));
        add_row(ROW_FRAME, 8'h00, 0, "k:v", 1'b0, '0);
        add_row(ROW_TEXT, 8'h00, 0, "<xy<", 1'b0, '0);
        add_row(ROW_FRAME, 8'h00, 0, "12345", 1'b0, '0);
        add_row(ROW_BYTE, CH_OPEN, 1, "", 1'b0, '0);
        add_row(ROW_BYTE, 8'h5A, MAX_FRAME_BYTES + 1, "", 1'b1, make_status(0, 1, 5, 8, 6));
        add_row(ROW_BYTE, CH_CLOSE, 1, "", 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table with no idling
        foreach (stim_rows[k])
        begin
            case (stim_rows[k].kind)
                ROW_BYTE:
                begin
                    repeat (stim_rows[k].reps) tx_bytes.push_back(stim_rows[k].ch);
                end
                ROW_TEXT:
                begin
                    push_text(stim_rows[k].text);
                end
                default:
                begin
                    // checksum covers the bytes between '<' and the colon
                    tx_bytes.push_back(CH_OPEN);
                    push_text(stim_rows[k].text);
                    row_sum = xor_from(1);
                    tx_bytes.push_back(CH_COLON);
                    push_text(hex_text(row_sum));
                    tx_bytes.push_back(CH_CLOSE);
                end
            endcase
            flush_bytes(stim_rows[k].pinned, stim_rows[k].fixed);
        end

        // random traffic under four idling patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct   = 48;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct   = 0;
                    out_stall_pct = 48;
                end
                default:
                begin
                    in_idle_pct   = 21;
                    out_stall_pct = 21;
                end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                if ($urandom_range(99) < 85)
                begin
                    build_random_frame();
                end
                else
                begin
                    repeat ($urandom_range(1, 8)) tx_bytes.push_back(byte_t'($urandom_range(255)));
                end
                flush_bytes(1'b0, '0);
            end
            // sender holds off until every result is in
            rx_if.valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_status.size() != 0);
        end

        // let any stray result show up
        repeat (4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
